[src/radial_profile_gap_fill_normalize_assert.svh]
// Assertion macros for the radial profile gap fill and normalize block.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef RADIAL_PROFILE_GAP_FILL_NORMALIZE_ASSERT_SVH
`define RADIAL_PROFILE_GAP_FILL_NORMALIZE_ASSERT_SVH

// Same-cycle implication
`define RPGF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RPGF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rpgf_pkg.sv]
// Shared constants and types for the radial profile gap fill block.
// No dependencies; imported by every module of the block.
package rpgf_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DIST_W      = 16;
    localparam int ENTRY_W     = DIST_W + 1;
    localparam int MISS_BIT    = DIST_W;
    localparam int FRAC_W      = 14;
    localparam int CFG_ADDR_W  = 8;
    localparam int Q_DEPTH     = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_LEVEL = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_LEVEL = CFG_ADDR_W'(1);

    // Store write request from the loader
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } t_wr_req;

    // Job handed from loader to the repair/normalize engine
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] n;
    } t_job;

endpackage

[src/rpgf_front.sv]
// Sample loader: accepts samples, writes the profile store, hands off jobs.
// Depends on rpgf_pkg.
module rpgf_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rpgf_pkg::DIST_W-1:0]     i_s_tdata,   // [15:0] distance
    input  logic                            i_s_tuser,   // [0] missing
    input  logic                            i_s_tlast,
    input  logic                            i_q_full,
    input  logic                            i_done,
    output rpgf_pkg::t_wr_req               o_wr,
    output rpgf_pkg::t_job                  o_push
);
    import rpgf_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_hold, n_hold;
    logic             w_acc;
    logic             w_full;

    assign o_s_tready = !r_hold && !i_q_full;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_full     = (r_cnt == CNT_W'(MAX_ENTRIES));

    // Store write; samples beyond the store depth are dropped
    always_comb begin
        o_wr.en   = w_acc && !w_full;
        o_wr.addr = r_cnt[ADDR_W-1:0];
        o_wr.data = i_s_tuser ? {1'b1, {DIST_W{1'b0}}} : {1'b0, i_s_tdata};
    end

    // Job push on the closing sample
    always_comb begin
        o_push.valid = w_acc && i_s_tlast;
        o_push.n     = w_full ? r_cnt : r_cnt + CNT_W'(1);
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_hold = r_hold;
        if (w_acc) begin
            if (i_s_tlast) begin
                n_cnt  = '0;
                n_hold = 1'b1;
            end else if (!w_full) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
        if (i_done) begin
            n_hold = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_hold <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_hold <= n_hold;
        end
    end

endmodule

[src/rpgf_queue.sv]
// Short job queue between the loader and the repair/normalize engine.
// Depends on rpgf_pkg.
module rpgf_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rpgf_pkg::t_job             i_push,
    input  logic                       i_pop,
    output logic                       o_full,
    output rpgf_pkg::t_job             o_head
);
    import rpgf_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int OCC_W = $clog2(Q_DEPTH + 1);

    logic [CNT_W-1:0] r_slot [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [OCC_W-1:0] r_occ;
    logic             w_wr, w_rd;

    assign o_full       = (r_occ == OCC_W'(Q_DEPTH));
    assign o_head.valid = (r_occ != '0);
    assign o_head.n     = r_slot[r_rptr];
    assign w_wr         = i_push.valid && !o_full;
    assign w_rd         = i_pop && o_head.valid;

    // Payload slots
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wptr] <= i_push.n;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_occ  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_occ <= r_occ + OCC_W'(1);
            end else if (w_rd && !w_wr) begin
                r_occ <= r_occ - OCC_W'(1);
            end
        end
    end

endmodule

[src/rpgf_back.sv]
// Repair walk, serial normalize divide and output register.
// Owns the profile store memory. Depends on rpgf_pkg.
module rpgf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rpgf_pkg::t_wr_req           i_wr,
    input  rpgf_pkg::t_job              i_job,
    output logic                        o_pop,
    input  logic [rpgf_pkg::DIST_W-1:0] i_min_level,
    input  logic [rpgf_pkg::DIST_W-1:0] i_max_level,
    output logic                        o_done,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [rpgf_pkg::DIST_W-1:0] o_m_tdata,   // [15:0] normalized
    output logic                        o_m_tuser,   // [0] range_error
    output logic                        o_m_tlast
);
    import rpgf_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_RRD  = 10'b00_0000_0010,
        ST_RCHK = 10'b00_0000_0100,
        ST_DRD  = 10'b00_0000_1000,
        ST_DCHK = 10'b00_0001_0000,
        ST_NRD  = 10'b00_0010_0000,
        ST_NLD  = 10'b00_0100_0000,
        ST_DIV  = 10'b00_1000_0000,
        ST_FIN  = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        DON_MIRROR = 2'd0,
        DON_NEXT   = 2'd1,
        DON_PREV   = 2'd2
    } t_donor;

    localparam int STEP_W = $clog2(DIST_W);

    // Profile store
    logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
    logic [ENTRY_W-1:0] r_rd_data;

    t_state             r_state, n_state;
    t_donor             r_sel, n_sel;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [DIST_W-1:0]  r_a, n_a;
    logic [DIST_W-1:0]  r_rem, n_rem;
    logic [DIST_W-1:0]  r_q, n_q;
    logic [DIST_W-1:0]  r_d, n_d;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_neg, n_neg;
    logic               r_ovf, n_ovf;
    logic               r_err, n_err;
    logic [DIST_W-1:0]  r_res, n_res;

    logic               r_out_valid;
    logic [DIST_W-1:0]  r_out_data;
    logic               r_out_err;
    logic               r_out_last;

    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr;
    logic               w_rep_we;
    logic [ENTRY_W-1:0] w_rep_wdata;
    logic               w_at_end;
    logic [ADDR_W-1:0]  w_mir, w_nxt, w_prv, w_don_addr;
    logic               w_is_donor;
    logic               w_slot_free;
    logic               w_load;
    logic [DIST_W:0]    w_diff, w_den, w_trial, w_sub;
    logic [DIST_W-1:0]  w_xmag, w_dmag;
    logic               w_ge;

    // Neighbor addresses, circular over the loaded entries
    always_comb begin
        w_at_end = ((CNT_W'(r_idx) + CNT_W'(1)) == r_n);
        w_mir    = ADDR_W'(r_n - CNT_W'(1) - CNT_W'(r_idx));
        w_nxt    = w_at_end ? '0 : r_idx + ADDR_W'(1);
        w_prv    = (r_idx == '0) ? ADDR_W'(r_n - CNT_W'(1)) : r_idx - ADDR_W'(1);
        case (r_sel)
            DON_MIRROR: w_don_addr = w_mir;
            DON_NEXT:   w_don_addr = w_nxt;
            DON_PREV:   w_don_addr = w_prv;
            default:    w_don_addr = w_mir;
        endcase
        w_is_donor = !r_rd_data[MISS_BIT] && (r_rd_data[DIST_W-1:0] != '0);
    end

    // Scaling setup: magnitudes of numerator and divisor
    always_comb begin
        w_diff = {1'b0, r_rd_data[DIST_W-1:0]} - {1'b0, i_min_level};
        w_den  = {1'b0, i_max_level} - {1'b0, i_min_level};
        w_xmag = w_diff[DIST_W] ? DIST_W'(-w_diff) : w_diff[DIST_W-1:0];
        w_dmag = w_den[DIST_W]  ? DIST_W'(-w_den)  : w_den[DIST_W-1:0];
    end

    // One restoring divide step
    always_comb begin
        w_trial = {r_rem, r_a[DIST_W-1]};
        w_ge    = (w_trial >= {1'b0, r_d});
        w_sub   = w_trial - {1'b0, r_d};
    end

    assign w_slot_free = !r_out_valid || i_m_tready;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_n         = r_n;
        n_idx       = r_idx;
        n_a         = r_a;
        n_rem       = r_rem;
        n_q         = r_q;
        n_d         = r_d;
        n_step      = r_step;
        n_neg       = r_neg;
        n_ovf       = r_ovf;
        n_err       = r_err;
        n_res       = r_res;
        w_re        = 1'b0;
        w_raddr     = r_idx;
        w_rep_we    = 1'b0;
        w_rep_wdata = '0;
        w_load      = 1'b0;
        o_pop       = 1'b0;
        o_done      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job.valid) begin
                    o_pop   = 1'b1;
                    n_n     = i_job.n;
                    n_idx   = '0;
                    n_state = ST_RRD;
                end
            end
            ST_RRD: begin
                w_re    = 1'b1;
                n_state = ST_RCHK;
            end
            ST_RCHK: begin
                if (r_rd_data[MISS_BIT]) begin
                    n_sel   = DON_MIRROR;
                    n_state = ST_DRD;
                end else if (w_at_end) begin
                    n_idx   = '0;
                    n_state = ST_NRD;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = ST_RRD;
                end
            end
            ST_DRD: begin
                w_re    = 1'b1;
                w_raddr = w_don_addr;
                n_state = ST_DCHK;
            end
            ST_DCHK: begin
                if (!w_is_donor && r_sel != DON_PREV) begin
                    n_sel   = (r_sel == DON_MIRROR) ? DON_NEXT : DON_PREV;
                    n_state = ST_DRD;
                end else begin
                    // Take the donor, or zero when none qualified
                    w_rep_we    = 1'b1;
                    w_rep_wdata = w_is_donor ? {1'b0, r_rd_data[DIST_W-1:0]} : '0;
                    if (w_at_end) begin
                        n_idx   = '0;
                        n_state = ST_NRD;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = ST_RRD;
                    end
                end
            end
            ST_NRD: begin
                w_re    = 1'b1;
                n_state = ST_NLD;
            end
            ST_NLD: begin
                n_err  = (i_max_level == i_min_level);
                n_neg  = w_diff[DIST_W] ^ w_den[DIST_W];
                n_ovf  = ({2'b00, w_xmag, {FRAC_W{1'b0}}} >= {w_dmag, {DIST_W{1'b0}}});
                n_d    = w_dmag;
                n_rem  = {2'b00, w_xmag[DIST_W-1:2]};
                n_a    = {w_xmag[1:0], {FRAC_W{1'b0}}};
                n_q    = '0;
                n_step = '0;
                n_state = (n_err || n_ovf) ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                n_rem  = w_ge ? w_sub[DIST_W-1:0] : w_trial[DIST_W-1:0];
                n_q    = {r_q[DIST_W-2:0], w_ge};
                n_a    = {r_a[DIST_W-2:0], 1'b0};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIST_W - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // Sign and saturation to signed Q2.14
                if (r_err) begin
                    n_res = '0;
                end else if (!r_neg) begin
                    n_res = (r_ovf || r_q[DIST_W-1]) ? {1'b0, {(DIST_W-1){1'b1}}} : r_q;
                end else begin
                    n_res = (r_ovf || r_q > {1'b1, {(DIST_W-1){1'b0}}}) ?
                            {1'b1, {(DIST_W-1){1'b0}}} : DIST_W'(-r_q);
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_slot_free) begin
                    w_load = 1'b1;
                    if (w_at_end) begin
                        o_done  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = ST_NRD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Store: loader writes while the engine is idle, repair writes otherwise
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end else if (w_rep_we) begin
            mem[r_idx] <= w_rep_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    // Engine registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sel  <= n_sel;
        r_n    <= n_n;
        r_idx  <= n_idx;
        r_a    <= n_a;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_d    <= n_d;
        r_step <= n_step;
        r_neg  <= n_neg;
        r_ovf  <= n_ovf;
        r_err  <= n_err;
        r_res  <= n_res;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_data <= r_res;
            r_out_err  <= r_err;
            r_out_last <= w_at_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_err;
    assign o_m_tlast  = r_out_last;

endmodule

[src/radial_profile_gap_fill_normalize.sv]
// Top level of the radial profile gap fill and normalize block.
// Instantiates rpgf_front, rpgf_queue and rpgf_back; uses rpgf_pkg and the assert header.
//
// Samples of one profile are taken one per cycle and written to a 64-entry store; the
// sample with tlast closes the profile. The input then stays held off until the last
// result of that profile has been placed in the output register. The engine first walks
// the entries through the store's single read port: a present entry takes a read and a
// check, a missing one adds a read and a check per donor tried in turn (mirror, next,
// previous). Each result then takes read, setup, a 16-step restoring divide, sign and
// saturation, and output load; the divide is skipped when the quotient magnitude needs
// more than 16 bits or the bounds are equal. Output stalls hold the engine only once
// the output register is full. No clearing pass follows reset. The bounds must be
// written through the configuration channel only while the block is idle, which it
// does not enforce. Index 0 is min_level, index 1 max_level; other indexes are ignored.
`include "radial_profile_gap_fill_normalize_assert.svh"

module radial_profile_gap_fill_normalize (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rpgf_pkg::DIST_W-1:0]     i_s_tdata,   // [15:0] distance
    input  logic                            i_s_tuser,   // [0] missing
    input  logic                            i_s_tlast,   // last_sample
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rpgf_pkg::DIST_W-1:0]     o_m_tdata,   // [15:0] normalized
    output logic                            o_m_tuser,   // [0] range_error
    output logic                            o_m_tlast,   // last_result
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rpgf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rpgf_pkg::DIST_W-1:0]     i_cfg_data
);
    import rpgf_pkg::*;

    logic [DIST_W-1:0] r_min_level;
    logic [DIST_W-1:0] r_max_level;
    t_wr_req           w_wr;
    t_job              w_push;
    t_job              w_head;
    logic              w_q_full;
    logic              w_pop;
    logic              w_done;
    logic              w_in_acc;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level <= '0;
            r_max_level <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                CFG_MIN_LEVEL: r_min_level <= i_cfg_data;
                CFG_MAX_LEVEL: r_max_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rpgf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (w_q_full),
        .i_done     (w_done),
        .o_wr       (w_wr),
        .o_push     (w_push)
    );

    rpgf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    rpgf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .i_job       (w_head),
        .o_pop       (w_pop),
        .i_min_level (r_min_level),
        .i_max_level (r_max_level),
        .o_done      (w_done),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // Input transaction, for the checks
    assign w_in_acc = i_s_tvalid && o_s_tready;

    // Checks
    `RPGF_ASSERT_NOW(a_err_zero, o_m_tvalid && o_m_tuser, o_m_tdata == '0, "value not zero")
    `RPGF_ASSERT_NOW(a_push_room, w_push.valid, !w_q_full, "job pushed into a full queue")
    `RPGF_ASSERT_NXT(a_hold_last, w_in_acc && i_s_tlast, !o_s_tready, "input not held")
    `RPGF_ASSERT_NXT(a_done_last, w_done, o_m_tvalid && o_m_tlast, "no last result at end")

endmodule
